FILE: hw/rtl/omni_three_wheel_pwm_mixer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the omni mixer
// Concurrent checks on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef OMNI_THREE_WHEEL_PWM_MIXER_ASSERT_SVH
`define OMNI_THREE_WHEEL_PWM_MIXER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define OTW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define OTW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define OTW_ASSERT_IMP(lbl, ante, cons, msg)
`define OTW_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/otw_mix_pkg.sv
// ----------------------------------------------------------------------------
// otw_mix_pkg
// Constants, register indexes and types for the three-wheel omni mixer.
// ----------------------------------------------------------------------------
package otw_mix_pkg;

  // stick sample and configuration widths
  localparam int unsigned STICK_W    = 8;
  localparam int unsigned DZ_W       = 7;
  localparam int unsigned REV_W      = 3;
  localparam int unsigned PWM_W      = 9;
  localparam int unsigned BRIDGE_W   = 2;
  localparam int unsigned MOTORS     = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;

  // default PWM resolution
  localparam int unsigned PWM_BITS_DEF = 8;

  // mixing arithmetic: motor sum is 32768 * 128 * duty
  localparam int unsigned SUM_W      = 26;
  localparam int unsigned MAG_W      = SUM_W - 1;
  localparam int unsigned FRAC_SHIFT = 22;
  localparam int unsigned HALF_SH    = 14;
  localparam int unsigned ONE_SH     = 15;
  localparam logic signed [SUM_W-1:0] COEF_ROOT3_HALF = SUM_W'(28378);
  localparam logic [MAG_W-1:0]        PWM_LIMIT       = MAG_W'(257);

  // configuration register reset values
  localparam logic [DZ_W-1:0]  DEAD_ZONE_RST     = DZ_W'(10);
  localparam logic [REV_W-1:0] MOTOR_REVERSE_RST = REV_W'(7);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEAD_ZONE     = 2'd0,
    REG_MOTOR_REVERSE = 2'd1
  } cfg_reg_t;

  // H-bridge direction pin codes
  localparam logic [BRIDGE_W-1:0] BRIDGE_OFF = 2'b00;
  localparam logic [BRIDGE_W-1:0] BRIDGE_FWD = 2'b01;
  localparam logic [BRIDGE_W-1:0] BRIDGE_REV = 2'b10;

  // one captured stick sample
  typedef struct packed {
    logic signed [STICK_W-1:0] stick_x;
    logic signed [STICK_W-1:0] stick_y;
    logic signed [STICK_W-1:0] stick_turn;
    logic                      connected;
  } sample_t;

  // zero an axis whose magnitude lies inside the dead zone
  function automatic logic signed [STICK_W-1:0] dz_apply(
    input logic signed [STICK_W-1:0] v,
    input logic [DZ_W-1:0]           dz
  );
    logic signed [STICK_W:0] vs;
    logic signed [STICK_W:0] dzs;
    vs  = {v[STICK_W-1], v};
    dzs = {2'b00, dz};
    if (vs >= dzs || vs <= -dzs) begin
      return v;
    end
    return '0;
  endfunction

endpackage

FILE: hw/rtl/omni_three_wheel_pwm_mixer.sv
// Sample register, then result register; throughput is one sample per cycle unless out_ready
// stalls. The constant-coefficient mix sits in one register stage.
// Reset (rst_n low, synchronous): pipeline empty, dead zone 10, all motors reversed,
// held direction pins cleared. Configuration writes are taken every cycle.
// ----------------------------------------------------------------------------
// omni_three_wheel_pwm_mixer
// Mixes three stick axes into PWM counts and H-bridge direction pins for a
// three-wheel omni base, with dead zone, per-motor reversal and overflow flag.
// ----------------------------------------------------------------------------
`include "omni_three_wheel_pwm_mixer_assert.svh"

module omni_three_wheel_pwm_mixer #(
  parameter int unsigned PWM_BITS = otw_mix_pkg::PWM_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // sample channel
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [otw_mix_pkg::STICK_W-1:0]  in_stick_x,
  input  logic signed [otw_mix_pkg::STICK_W-1:0]  in_stick_y,
  input  logic signed [otw_mix_pkg::STICK_W-1:0]  in_stick_turn,
  input  logic                                    in_connected,
  // result channel
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic [otw_mix_pkg::PWM_W-1:0]           out_pwm_one,
  output logic [otw_mix_pkg::PWM_W-1:0]           out_pwm_two,
  output logic [otw_mix_pkg::PWM_W-1:0]           out_pwm_three,
  output logic [otw_mix_pkg::BRIDGE_W-1:0]        out_bridge_one,
  output logic [otw_mix_pkg::BRIDGE_W-1:0]        out_bridge_two,
  output logic [otw_mix_pkg::BRIDGE_W-1:0]        out_bridge_three,
  output logic [otw_mix_pkg::MOTORS-1:0]          out_overflow_mask,
  // configuration write channel
  input  logic                                    cfg_valid,
  output logic                                    cfg_ready,
  input  logic [otw_mix_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [otw_mix_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int unsigned CNT_SHIFT = otw_mix_pkg::FRAC_SHIFT - PWM_BITS;

  // configuration registers
  logic [otw_mix_pkg::DZ_W-1:0]  dead_zone_r;
  logic [otw_mix_pkg::REV_W-1:0] motor_reverse_r;

  // sample register
  logic                 smp_valid_r;
  otw_mix_pkg::sample_t smp_r;

  // result register and held direction pins
  logic                                 out_valid_r;
  logic [otw_mix_pkg::PWM_W-1:0]        pwm_r     [otw_mix_pkg::MOTORS];
  logic [otw_mix_pkg::BRIDGE_W-1:0]     held_r    [otw_mix_pkg::MOTORS];
  logic [otw_mix_pkg::MOTORS-1:0]       ovf_r;
  logic [otw_mix_pkg::PWM_W-1:0]        pwm_nxt   [otw_mix_pkg::MOTORS];
  logic [otw_mix_pkg::BRIDGE_W-1:0]     held_nxt  [otw_mix_pkg::MOTORS];
  logic [otw_mix_pkg::MOTORS-1:0]       ovf_nxt;

  logic advance;
  logic in_xfer;

  // advance the sample into the result register when that register is free
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = !smp_valid_r || advance;
  assign in_xfer  = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_zone_r     <= otw_mix_pkg::DEAD_ZONE_RST;
      motor_reverse_r <= otw_mix_pkg::MOTOR_REVERSE_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        otw_mix_pkg::REG_DEAD_ZONE: begin
          dead_zone_r <= cfg_data[otw_mix_pkg::DZ_W-1:0];
        end
        otw_mix_pkg::REG_MOTOR_REVERSE: begin
          motor_reverse_r <= cfg_data[otw_mix_pkg::REV_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // capture the sample on transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_valid_r <= 1'b0;
    end else if (in_ready) begin
      smp_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      smp_r.stick_x    <= in_stick_x;
      smp_r.stick_y    <= in_stick_y;
      smp_r.stick_turn <= in_stick_turn;
      smp_r.connected  <= in_connected;
    end
  end

  // mix: dead zone, omni matrix, reversal, PWM count and direction per motor
  always_comb begin
    logic signed [otw_mix_pkg::STICK_W-1:0] xz;
    logic signed [otw_mix_pkg::STICK_W-1:0] yz;
    logic signed [otw_mix_pkg::STICK_W-1:0] tz;
    logic signed [otw_mix_pkg::SUM_W-1:0]   xe;
    logic signed [otw_mix_pkg::SUM_W-1:0]   ye;
    logic signed [otw_mix_pkg::SUM_W-1:0]   te;
    logic signed [otw_mix_pkg::SUM_W-1:0]   ymul;
    logic signed [otw_mix_pkg::SUM_W-1:0]   sum  [otw_mix_pkg::MOTORS];
    logic signed [otw_mix_pkg::SUM_W-1:0]   duty;
    logic [otw_mix_pkg::MAG_W-1:0]          mag;
    logic [otw_mix_pkg::MAG_W-1:0]          cnt;
    xz = otw_mix_pkg::dz_apply(smp_r.stick_x, dead_zone_r);
    yz = otw_mix_pkg::dz_apply(smp_r.stick_y, dead_zone_r);
    tz = otw_mix_pkg::dz_apply(smp_r.stick_turn, dead_zone_r);
    xe = otw_mix_pkg::SUM_W'(xz);
    ye = otw_mix_pkg::SUM_W'(yz);
    // turn axis is negated
    te = -otw_mix_pkg::SUM_W'(tz);
    ymul = otw_mix_pkg::SUM_W'(ye * otw_mix_pkg::COEF_ROOT3_HALF);
    sum[0] = (te - xe) <<< otw_mix_pkg::ONE_SH;
    sum[1] = (xe <<< otw_mix_pkg::HALF_SH) - ymul + (te <<< otw_mix_pkg::ONE_SH);
    sum[2] = (xe <<< otw_mix_pkg::HALF_SH) + ymul + (te <<< otw_mix_pkg::ONE_SH);
    ovf_nxt = '0;
    for (int k = 0; k < otw_mix_pkg::MOTORS; k++) begin
      duty = motor_reverse_r[k] ? -sum[k] : sum[k];
      mag  = duty[otw_mix_pkg::SUM_W-1] ? otw_mix_pkg::MAG_W'(-duty)
                                         : otw_mix_pkg::MAG_W'(duty);
      cnt  = mag >> CNT_SHIFT;
      if (!smp_r.connected) begin
        // link down frees every motor
        pwm_nxt[k]  = '0;
        held_nxt[k] = otw_mix_pkg::BRIDGE_OFF;
      end else if (cnt >= otw_mix_pkg::PWM_LIMIT) begin
        // out of range: zero the PWM and hold the pins
        pwm_nxt[k]  = '0;
        held_nxt[k] = held_r[k];
        ovf_nxt[k]  = 1'b1;
      end else begin
        pwm_nxt[k]  = cnt[otw_mix_pkg::PWM_W-1:0];
        held_nxt[k] = (duty > 0) ? otw_mix_pkg::BRIDGE_FWD : otw_mix_pkg::BRIDGE_REV;
      end
    end
  end

  // result register and held direction pins
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      for (int k = 0; k < otw_mix_pkg::MOTORS; k++) begin
        held_r[k] <= otw_mix_pkg::BRIDGE_OFF;
      end
    end else if (advance) begin
      out_valid_r <= smp_valid_r;
      if (smp_valid_r) begin
        for (int k = 0; k < otw_mix_pkg::MOTORS; k++) begin
          held_r[k] <= held_nxt[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && smp_valid_r) begin
      for (int k = 0; k < otw_mix_pkg::MOTORS; k++) begin
        pwm_r[k] <= pwm_nxt[k];
      end
      ovf_r <= ovf_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pwm_one       = pwm_r[0];
  assign out_pwm_two       = pwm_r[1];
  assign out_pwm_three     = pwm_r[2];
  assign out_bridge_one    = held_r[0];
  assign out_bridge_two    = held_r[1];
  assign out_bridge_three  = held_r[2];
  assign out_overflow_mask = ovf_r;

  // checks
  `OTW_ASSERT_IMP(a_ready_when_empty, !out_valid_r, in_ready,
    "sample side stalled with an empty result register")
  `OTW_ASSERT_IMP(a_ovf_zero_pwm, out_valid_r && ovf_r[0], pwm_r[0] == '0,
    "overflowed motor drives a non-zero PWM")
  `OTW_ASSERT_IMP(a_bridge_legal, out_valid_r,
    held_r[0] != 2'b11 && held_r[1] != 2'b11 && held_r[2] != 2'b11,
    "both bridge inputs driven high")
  `OTW_ASSERT_NXT(a_result_follows, smp_valid_r && advance, out_valid_r,
    "captured sample lost on its way to the result register")

endmodule
